// ===== rtl/srev_pkg.sv =====
// ----------------------------------------------------------------------------
// srev_pkg
// Shared types and constants of the sumcheck round evaluator.
// ----------------------------------------------------------------------------
package srev_pkg;

  // Residue width and table depth.
  localparam int unsigned RES_W  = 62;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned BIT_W  = 6;
  localparam int unsigned CNT_W  = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODULUS  = 2'd0;
  localparam logic [1:0] REG_LOG_SIZE = 2'd1;
  localparam logic [1:0] REG_EVAL_VAR = 2'd2;
  localparam logic [1:0] REG_PRODUCT  = 2'd3;

  // Request kinds carried on the input tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // Operations of the shared modular unit.
  typedef enum logic [1:0] {
    OP_STEP,
    OP_ADD,
    OP_SUB
  } alu_op_e;

  // Control word handed to the modular unit.
  typedef struct packed {
    alu_op_e op;
    logic    mbit;
  } alu_ctl_t;

endpackage

// ===== rtl/sumcheck_round_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// sumcheck_round_evaluator_core
// One sumcheck prover round over two residue tables held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage: items on the slave stream are load or start requests, told apart by
// tuser. A load writes one f and g entry. A start walks 2^(log_size-1) entry
// pairs through one shared modular unit, then sends the round polynomial
// values on the master stream, t = 0 first, tlast on the final one (t = 2 in
// product mode, t = 1 in linear mode). An invalid round setting gives one
// item with tuser set and value zero.
// Flow: each pair passes the memory read states RDA, RDB and RDW, then jobs
// on the bit-serial modular unit: four reductions and three products in
// product mode, two reductions and two additions in linear mode. The slave
// side is ready only while idle, so a round holds off further items until
// its last result is taken.
// Stall: results wait in the output register while tready is low.
// Reset clears control state and sums; configuration returns to modulus 2,
// log_size 1, eval_var 0, product mode; tables are undefined until loaded.
// Configuration writes are always taken; the user makes them only when idle.
// ----------------------------------------------------------------------------
module sumcheck_round_evaluator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream. tdata: entry_index, f_value, g_value, zero pad.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,
  // tuser: req_type.
  input  logic [0:0]   s_axis_tuser_i,
  // Output stream. tdata: eval_point, eval_value.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  // tuser: bad_config.
  output logic [0:0]   m_axis_tuser_o,
  // Configuration write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [61:0]  cfg_data_i
);
  import srev_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDA  = 3'd1;
  localparam logic [2:0] ST_RDB  = 3'd2;
  localparam logic [2:0] ST_RDW  = 3'd3;
  localparam logic [2:0] ST_JOB  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // Per-pair job list.
  localparam logic [3:0] J_RFL = 4'd0;
  localparam logic [3:0] J_RFH = 4'd1;
  localparam logic [3:0] J_RGL = 4'd2;
  localparam logic [3:0] J_RGH = 4'd3;
  localparam logic [3:0] J_EF1 = 4'd4;
  localparam logic [3:0] J_EF2 = 4'd5;
  localparam logic [3:0] J_EG1 = 4'd6;
  localparam logic [3:0] J_EG2 = 4'd7;
  localparam logic [3:0] J_M0  = 4'd8;
  localparam logic [3:0] J_A0  = 4'd9;
  localparam logic [3:0] J_M1  = 4'd10;
  localparam logic [3:0] J_A1  = 4'd11;
  localparam logic [3:0] J_M2  = 4'd12;
  localparam logic [3:0] J_A2  = 4'd13;
  localparam logic [3:0] J_L0  = 4'd14;
  localparam logic [3:0] J_L1  = 4'd15;

  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(RES_W - 1);
  localparam logic [CNT_W-1:0] MAX_LOG = CNT_W'(ADDR_W);

  // Configuration registers.
  logic [RES_W-1:0]  mod_q;
  logic [CNT_W-1:0]  ls_q;
  logic [CNT_W-1:0]  ev_q;
  logic              prod_q;

  // Sequencer and datapath registers.
  logic [2:0]        state_q, state_d;
  logic [3:0]        job_q;
  logic [BIT_W-1:0]  k_q;
  logic [ADDR_W-1:0] i_q;
  logic [1:0]        point_q;
  logic              bad_q;
  logic [RES_W-1:0]  fl_q, fh_q, gl_q, gh_q, ef_q, eg_q, acc_q;
  logic [RES_W-1:0]  s0_q, s1_q, s2_q;

  // Tables.
  logic [RES_W-1:0]  f_mem [DEPTH];
  logic [RES_W-1:0]  g_mem [DEPTH];
  logic [RES_W-1:0]  f_rd_q, g_rd_q;

  logic              in_acc, out_acc, start_bad;
  logic [ADDR_W-1:0] wr_idx, rd_addr, addr_a, addr_b, low_mask, last_pair;
  logic [RES_W-1:0]  q_eff;

  alu_ctl_t          ctl;
  logic [RES_W-1:0]  op_a, op_b, op_x, alu_res;
  logic              serial;
  logic [3:0]        next_job;
  logic              pair_done, is_last;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign wr_idx          = s_axis_tdata_i[ADDR_W-1:0];
  assign start_bad       = (ev_q >= ls_q) || (ls_q > MAX_LOG);
  assign q_eff           = (mod_q < RES_W'(2)) ? RES_W'(2) : mod_q;

  // Pair addresses: a zero bit inserted at position eval_var.
  assign low_mask  = (ADDR_W'(1) << ev_q) - ADDR_W'(1);
  assign addr_a    = ((i_q >> ev_q) << (ev_q + CNT_W'(1))) | (i_q & low_mask);
  assign addr_b    = addr_a | (ADDR_W'(1) << ev_q);
  assign last_pair = (ADDR_W'(1) << (ls_q - CNT_W'(1))) - ADDR_W'(1);
  assign rd_addr   = (state_q == ST_RDA) ? addr_a : addr_b;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= RES_W'(2);
      ls_q   <= CNT_W'(1);
      ev_q   <= '0;
      prod_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MODULUS:  mod_q  <= cfg_data_i;
        REG_LOG_SIZE: ls_q   <= cfg_data_i[CNT_W-1:0];
        REG_EVAL_VAR: ev_q   <= cfg_data_i[CNT_W-1:0];
        REG_PRODUCT:  prod_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Table memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser_i[0] == REQ_LOAD) begin
      f_mem[wr_idx] <= s_axis_tdata_i[ADDR_W +: RES_W];
      g_mem[wr_idx] <= s_axis_tdata_i[ADDR_W+RES_W +: RES_W];
    end
    f_rd_q <= f_mem[rd_addr];
    g_rd_q <= g_mem[rd_addr];
  end

  // Job decode: operands and operation for the shared unit.
  always_comb begin
    serial = 1'b0;
    op_a   = '0;
    op_b   = '0;
    op_x   = '0;
    case (job_q)
      J_RFL: begin serial = 1'b1; op_a = RES_W'(1); op_x = fl_q; end
      J_RFH: begin serial = 1'b1; op_a = RES_W'(1); op_x = fh_q; end
      J_RGL: begin serial = 1'b1; op_a = RES_W'(1); op_x = gl_q; end
      J_RGH: begin serial = 1'b1; op_a = RES_W'(1); op_x = gh_q; end
      J_EF1: begin op_a = fh_q; op_b = fh_q; end
      J_EF2: begin op_a = ef_q; op_b = fl_q; end
      J_EG1: begin op_a = gh_q; op_b = gh_q; end
      J_EG2: begin op_a = eg_q; op_b = gl_q; end
      J_M0:  begin serial = 1'b1; op_a = fl_q; op_x = gl_q; end
      J_A0:  begin op_a = s0_q; op_b = acc_q; end
      J_M1:  begin serial = 1'b1; op_a = fh_q; op_x = gh_q; end
      J_A1:  begin op_a = s1_q; op_b = acc_q; end
      J_M2:  begin serial = 1'b1; op_a = ef_q; op_x = eg_q; end
      J_A2:  begin op_a = s2_q; op_b = acc_q; end
      J_L0:  begin op_a = s0_q; op_b = fl_q; end
      J_L1:  begin op_a = s1_q; op_b = fh_q; end
      default: ;
    endcase
    if (serial) begin
      // The running remainder starts from zero on the first step.
      op_b = (k_q == BIT_TOP) ? '0 : acc_q;
    end
    ctl.mbit = op_x[k_q];
    case (job_q)
      J_EF2, J_EG2: ctl.op = OP_SUB;
      default:      ctl.op = serial ? OP_STEP : OP_ADD;
    endcase
  end

  srev_modalu u_alu (
    .ctl_i (ctl),
    .q_i   (q_eff),
    .a_i   (op_a),
    .b_i   (op_b),
    .res_o (alu_res)
  );

  // Job ordering and end of pair.
  always_comb begin
    next_job  = job_q + 4'd1;
    pair_done = 1'b0;
    if (job_q == J_RFH && !prod_q) begin
      next_job = J_L0;
    end
    if (job_q == J_A2 || job_q == J_L1) begin
      pair_done = 1'b1;
      next_job  = J_RFL;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser_i[0] == REQ_START) begin
          state_d = start_bad ? ST_OUT : ST_RDA;
        end
      end
      ST_RDA: state_d = ST_RDB;
      ST_RDB: state_d = ST_RDW;
      ST_RDW: state_d = ST_JOB;
      ST_JOB: begin
        if ((!serial || k_q == '0) && pair_done) begin
          state_d = (i_q == last_pair) ? ST_OUT : ST_RDA;
        end
      end
      ST_OUT: begin
        if (out_acc && is_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= J_RFL;
      k_q     <= BIT_TOP;
      i_q     <= '0;
      point_q <= '0;
      bad_q   <= 1'b0;
      s0_q    <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser_i[0] == REQ_START) begin
            bad_q   <= start_bad;
            point_q <= '0;
            i_q     <= '0;
            job_q   <= J_RFL;
            k_q     <= BIT_TOP;
            if (!start_bad) begin
              s0_q <= '0;
              s1_q <= '0;
              s2_q <= '0;
            end
          end
        end
        ST_JOB: begin
          if (serial && k_q != '0) begin
            k_q <= k_q - BIT_W'(1);
          end else begin
            k_q   <= BIT_TOP;
            job_q <= next_job;
            case (job_q)
              J_A0, J_L0: s0_q <= alu_res;
              J_A1, J_L1: s1_q <= alu_res;
              J_A2:       s2_q <= alu_res;
              default: ;
            endcase
            if (pair_done) begin
              i_q <= i_q + ADDR_W'(1);
            end
          end
        end
        ST_OUT: begin
          if (out_acc && !is_last) begin
            point_q <= point_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Operand registers of the pair being worked on.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RDB) begin
      fl_q <= f_rd_q;
      gl_q <= g_rd_q;
    end
    if (state_q == ST_RDW) begin
      fh_q <= f_rd_q;
      gh_q <= g_rd_q;
    end
    if (state_q == ST_JOB) begin
      if (serial) begin
        acc_q <= alu_res;
      end
      if (!serial || k_q == '0) begin
        case (job_q)
          J_RFL:        fl_q <= alu_res;
          J_RFH:        fh_q <= alu_res;
          J_RGL:        gl_q <= alu_res;
          J_RGH:        gh_q <= alu_res;
          J_EF1, J_EF2: ef_q <= alu_res;
          J_EG1, J_EG2: eg_q <= alu_res;
          default: ;
        endcase
      end
    end
  end

  // Result stream.
  assign is_last = bad_q || (point_q == (prod_q ? 2'd2 : 2'd1));
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tlast_o  = is_last;
  assign m_axis_tuser_o  = bad_q;
  always_comb begin
    m_axis_tdata_o[1:0] = point_q;
    case (point_q)
      2'd0:    m_axis_tdata_o[63:2] = s0_q;
      2'd1:    m_axis_tdata_o[63:2] = s1_q;
      default: m_axis_tdata_o[63:2] = s2_q;
    endcase
    if (bad_q) begin
      m_axis_tdata_o[63:2] = '0;
    end
  end

  // Checks.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while a result is pending");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= BIT_TOP)
    else $error("serial step counter out of range");

  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && bad_q) |-> (point_q == 2'd0 && m_axis_tlast_o))
    else $error("error result is not a single item");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_JOB) |-> (i_q <= last_pair))
    else $error("pair index beyond table");

  a_linear_jobs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_JOB && !prod_q) |->
      (job_q == J_RFL || job_q == J_RFH || job_q == J_L0 || job_q == J_L1))
    else $error("product job in linear mode");

endmodule

// ===== rtl/srev_modalu.sv =====
// ----------------------------------------------------------------------------
// srev_modalu
// Shared modular unit: one double-and-add step of a bit-serial product,
// or a single modular addition or subtraction, all below modulus q.
// ----------------------------------------------------------------------------
module srev_modalu (
  input  srev_pkg::alu_ctl_t             ctl_i,
  input  logic [srev_pkg::RES_W-1:0]     q_i,
  input  logic [srev_pkg::RES_W-1:0]     a_i,
  input  logic [srev_pkg::RES_W-1:0]     b_i,
  output logic [srev_pkg::RES_W-1:0]     res_o
);
  import srev_pkg::*;

  logic [RES_W:0]   dbl_sum;
  logic [RES_W-1:0] dbl;
  logic [RES_W-1:0] addend;
  logic [RES_W:0]   acc_sum;
  logic [RES_W-1:0] acc;
  logic [RES_W:0]   pl_sum;
  logic [RES_W-1:0] pl;
  logic [RES_W-1:0] mi;

  // Step: r' = (2r + bit*a) mod q, with r on b_i.
  always_comb begin
    dbl_sum = {1'b0, b_i} + {1'b0, b_i};
    if (dbl_sum >= {1'b0, q_i}) begin
      dbl_sum = dbl_sum - {1'b0, q_i};
    end
    dbl     = dbl_sum[RES_W-1:0];
    addend  = ctl_i.mbit ? a_i : '0;
    acc_sum = {1'b0, dbl} + {1'b0, addend};
    if (acc_sum >= {1'b0, q_i}) begin
      acc_sum = acc_sum - {1'b0, q_i};
    end
    acc = acc_sum[RES_W-1:0];
  end

  // Plain modular sum and difference.
  always_comb begin
    pl_sum = {1'b0, a_i} + {1'b0, b_i};
    if (pl_sum >= {1'b0, q_i}) begin
      pl_sum = pl_sum - {1'b0, q_i};
    end
    pl = pl_sum[RES_W-1:0];
    mi = a_i - b_i;
    if (a_i < b_i) begin
      mi = mi + q_i;
    end
  end

  always_comb begin
    case (ctl_i.op)
      OP_STEP: res_o = acc;
      OP_ADD:  res_o = pl;
      OP_SUB:  res_o = mi;
      default: res_o = '0;
    endcase
  end

endmodule

// ===== tb/sumcheck_round_evaluator_core_tb.sv =====
// ----------------------------------------------------------------------------
// sumcheck_round_evaluator_core_tb
// Self-checking bench for the sumcheck round evaluator core. Load and start
// items are streamed in bursts with random gaps while the result side stalls
// on a pattern of its own. A scoreboard keeps its own copy of the f and g
// tables and the round settings, works out the round polynomial values of
// every start item and checks each result item field by field, in order.
// ----------------------------------------------------------------------------
module sumcheck_round_evaluator_core_tb;
  import srev_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam bit [61:0]   RES_MAX     = {62{1'b1}};
  localparam logic [1:0]  POINT_ZERO  = 2'd0;
  localparam logic [1:0]  POINT_ONE   = 2'd1;
  localparam logic [1:0]  POINT_TWO   = 2'd2;

  typedef struct {
    bit [1:0]  point;
    bit [61:0] value;
    bit        last;
    bit        bad;
  } eval_item_t;

  // Scoreboard: holds the tables and settings, predicts each round.
  class round_scoreboard;
    bit [61:0]  f_mem [DEPTH];
    bit [61:0]  g_mem [DEPTH];
    bit         written [DEPTH];
    bit [61:0]  modulus = 62'd2;
    bit [3:0]   log_size = 4'd1;
    bit [3:0]   eval_var = 4'd0;
    bit         product = 1'b1;
    eval_item_t expected_evals[$];
    int         errors;

    function void push_eval(bit [1:0] pt, bit [61:0] v, bit lst, bit bad);
      eval_item_t e;
      e.point = pt;
      e.value = v;
      e.last  = lst;
      e.bad   = bad;
      expected_evals.push_back(e);
    endfunction

    function bit round_invalid();
      return (eval_var >= log_size) || (log_size > ADDR_W);
    endfunction

    // Note an accepted input item and queue the results it causes.
    function void note_request(bit req, bit [9:0] idx, bit [61:0] fv, bit [61:0] gv);
      bit [63:0]  q, flo, fhi, glo, ghi, ef, eg, s0, s1, s2;
      bit [123:0] prod;
      int unsigned stride, pairs, lo, hi;
      if (req == REQ_LOAD) begin
        f_mem[idx]   = fv;
        g_mem[idx]   = gv;
        written[idx] = 1'b1;
        return;
      end
      if (round_invalid()) begin
        push_eval(POINT_ZERO, '0, 1'b1, 1'b1);
        return;
      end
      q = (modulus < 2) ? 64'd2 : 64'(modulus);
      stride = 1 << eval_var;
      pairs  = 1 << (log_size - 1);
      s0 = 0;
      s1 = 0;
      s2 = 0;
      for (int unsigned i = 0; i < pairs; i++) begin
        lo  = (i & (stride - 1)) | ((i >> eval_var) << (eval_var + 1));
        hi  = lo + stride;
        flo = 64'(f_mem[lo]) % q;
        fhi = 64'(f_mem[hi]) % q;
        if (product) begin
          glo  = 64'(g_mem[lo]) % q;
          ghi  = 64'(g_mem[hi]) % q;
          ef   = (2 * fhi + q - flo) % q;
          eg   = (2 * ghi + q - glo) % q;
          prod = 124'(flo) * 124'(glo);
          s0   = (s0 + 64'(prod % q)) % q;
          prod = 124'(fhi) * 124'(ghi);
          s1   = (s1 + 64'(prod % q)) % q;
          prod = 124'(ef) * 124'(eg);
          s2   = (s2 + 64'(prod % q)) % q;
        end else begin
          s0 = (s0 + flo) % q;
          s1 = (s1 + fhi) % q;
        end
      end
      push_eval(POINT_ZERO, s0[61:0], 1'b0, 1'b0);
      push_eval(POINT_ONE, s1[61:0], !product, 1'b0);
      if (product) push_eval(POINT_TWO, s2[61:0], 1'b1, 1'b0);
    endfunction

    // Compare one accepted result item with the oldest expectation.
    function void check_result(bit [1:0] pt, bit [61:0] v, bit lst, bit bad);
      eval_item_t e;
      if (expected_evals.size() == 0) begin
        $error("unexpected result item: eval_point %0d eval_value %0h", pt, v);
        errors++;
        return;
      end
      e = expected_evals.pop_front();
      if (pt != e.point) begin
        $error("eval_point: expected %0d, actual %0d", e.point, pt);
        errors++;
      end
      if (v != e.value) begin
        $error("eval_value: expected %0h, actual %0h", e.value, v);
        errors++;
      end
      if (lst != e.last) begin
        $error("last: expected %0d, actual %0d", e.last, lst);
        errors++;
      end
      if (bad != e.bad) begin
        $error("bad_config: expected %0d, actual %0d", e.bad, bad);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  logic [135:0]  s_axis_tdata_i = '0;
  logic [0:0]    s_axis_tuser_i = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  logic [63:0]   m_axis_tdata_o;
  logic          m_axis_tlast_o;
  logic [0:0]    m_axis_tuser_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i = '0;
  logic [61:0]   cfg_data_i = '0;

  round_scoreboard sb = new();
  int unsigned     cycle_count;
  int unsigned     burst_left;
  bit              tx_steady;
  bit              rx_steady;
  int unsigned     rx_left;

  sumcheck_round_evaluator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter with a watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sumcheck_round_evaluator_core_tb: done, errors");
      $finish;
    end
  end

  // Result side: check accepted items and stall on its own pattern.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o[1:0], m_axis_tdata_o[63:2], m_axis_tlast_o,
                      m_axis_tuser_o[0]);
    end
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (m_axis_tready_i || rx_steady) begin
      m_axis_tready_i <= !m_axis_tready_i && !rx_steady ? 1'b1 : !rx_steady ? 1'b0 : 1'b1;
      rx_left         <= rx_steady ? 0 : $urandom_range(0, 7);
    end else begin
      m_axis_tready_i <= 1'b1;
      rx_left         <= $urandom_range(0, 12);
    end
  end

  // Send one item; valid stays high after acceptance unless a gap follows.
  task automatic send_item(bit req, bit [9:0] idx, bit [61:0] fv, bit [61:0] gv);
    if (burst_left == 0) begin
      if (!tx_steady) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {2'b00, gv, fv, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(req, idx, fv, gv);
  endtask

  // Let the block go idle: no item in flight and no result owed.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected_evals.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, bit [61:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      REG_MODULUS:  sb.modulus  = value;
      REG_LOG_SIZE: sb.log_size = value[3:0];
      REG_EVAL_VAR: sb.eval_var = value[3:0];
      default:      sb.product  = value[0];
    endcase
  endtask

  task automatic setup_round(bit [61:0] q, bit [3:0] lg, bit [3:0] ev, bit prod);
    write_reg(REG_MODULUS, q);
    write_reg(REG_LOG_SIZE, lg);
    write_reg(REG_EVAL_VAR, ev);
    write_reg(REG_PRODUCT, 62'(prod));
  endtask

  function automatic bit [61:0] rand_residue();
    return 62'({$urandom(), $urandom()} >> 2);
  endfunction

  // Mixed loads and starts; a start is sent only once the live table is loaded or the round setting is invalid.
  task automatic run_items(int unsigned count, int unsigned start_pct);
    int unsigned live, hole;
    bit          ready_to_run;
    for (int unsigned n = 0; n < count; n++) begin
      live = sb.log_size > ADDR_W ? DEPTH : (1 << sb.log_size);
      hole = live;
      for (int unsigned k = 0; k < live; k++) begin
        if (!sb.written[k]) begin
          hole = k;
          break;
        end
      end
      ready_to_run = sb.round_invalid() || hole == live;
      if (ready_to_run && $urandom_range(0, 99) < start_pct) begin
        send_item(REQ_START, 10'($urandom()), rand_residue(), rand_residue());
      end else if (hole != live) begin
        send_item(REQ_LOAD, 10'(hole), rand_residue(), rand_residue());
        n--;
      end else begin
        send_item(REQ_LOAD, 10'($urandom()), rand_residue(), rand_residue());
      end
    end
  endtask

  initial begin
    bit [61:0] q;
    bit [3:0]  lg, ev;
    rx_steady = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extreme values, low moduli, both modes.
    tx_steady = 1'b1;
    send_item(REQ_LOAD, 10'd0, RES_MAX, RES_MAX);
    send_item(REQ_LOAD, 10'd1, '0, RES_MAX);
    send_item(REQ_START, '0, '0, '0);
    write_reg(REG_MODULUS, 62'd0);
    send_item(REQ_START, '1, RES_MAX, RES_MAX);
    write_reg(REG_MODULUS, 62'd1);
    send_item(REQ_START, '0, '0, '0);
    write_reg(REG_MODULUS, RES_MAX);
    send_item(REQ_LOAD, 10'd1023, RES_MAX, 62'd1);
    send_item(REQ_LOAD, 10'd1, RES_MAX - 1, RES_MAX - 2);
    send_item(REQ_START, '0, '0, '0);
    write_reg(REG_PRODUCT, 62'd0);
    send_item(REQ_START, '0, '0, '0);
    // Round settings that must be flagged as invalid.
    write_reg(REG_EVAL_VAR, 62'd1);
    send_item(REQ_START, '0, '0, '0);
    write_reg(REG_EVAL_VAR, 62'd15);
    send_item(REQ_START, '0, '0, '0);
    write_reg(REG_LOG_SIZE, 62'd0);
    write_reg(REG_EVAL_VAR, 62'd0);
    send_item(REQ_START, '0, '0, '0);
    write_reg(REG_LOG_SIZE, 62'd15);
    send_item(REQ_START, '0, '0, '0);

    // Random phases on small tables.
    for (int p = 0; p < 9; p++) begin
      tx_steady = (p % 3 == 2);
      rx_steady = (p % 4 == 3);
      case ($urandom_range(0, 4))
        0:       q = 62'd2;
        1:       q = RES_MAX;
        2:       q = 62'($urandom_range(3, 1000));
        3:       q = 62'd1 << 61 | 62'd1;
        default: q = rand_residue();
      endcase
      lg = 4'($urandom_range(1, 4));
      ev = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(lg, 15))
                                        : 4'($urandom_range(0, lg - 1));
      setup_round(q, lg, ev, 1'($urandom()));
      run_items(8, 35);
    end

    // Larger table in both modes, at both edge variables.
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    setup_round(rand_residue(), 4'd5, 4'd4, 1'b1);
    run_items(1, 100);
    setup_round(RES_MAX, 4'd5, 4'd0, 1'b0);
    run_items(2, 60);

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_evals.size() == 0) begin
      $display("sumcheck_round_evaluator_core_tb: done, clean");
    end else begin
      $display("sumcheck_round_evaluator_core_tb: done, errors");
    end
    $finish;
  end

endmodule
